// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the weight accumulator RTL
// Clocked implication and never-true checks, both off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/hwa_pkg.sv =====
// ---------------------------------------------------------------------------
// hwa_pkg - shared types and constants
// Field widths, request codes and the command word passed front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package hwa_pkg;

    // fixed field widths
    localparam int REQ_W     = 2;
    localparam int PATTERN_W = 64;
    localparam int INDEX_W   = 6;
    localparam int SUM_W     = 9;
    localparam int WEIGHT_W  = 19;
    localparam int COUNT_W   = 8;
    localparam int FRAC_W    = 16;

    localparam int SUM_LIMIT  = 255;
    localparam int COUNT_LIM  = 255;
    localparam int WEIGHT_MAX = 2 ** (WEIGHT_W - 1) - 1;
    localparam int WEIGHT_MIN = -(2 ** (WEIGHT_W - 1));

    // defaults for the top-level parameters
    localparam int DEF_NEURONS      = 64;
    localparam int DEF_MAX_PATTERNS = 255;

    // command queue depth
    localparam int QUEUE_DEPTH = 2;

    // request codes on req_type
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_TRAIN = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [PATTERN_W-1:0] pattern;
        logic [INDEX_W-1:0]   row;
        logic [INDEX_W-1:0]   col;
        logic                 rd_zero;   // read answers zero (diagonal / out of range)
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/hwa_ram.sv =====
// ---------------------------------------------------------------------------
// hwa_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/hwa_front.sv =====
// ---------------------------------------------------------------------------
// hwa_front - request intake and classification
// Decodes the request type and pre-checks read indices into a command word.
// ---------------------------------------------------------------------------
`default_nettype none

module hwa_front
    import hwa_pkg::*;
#(
    parameter int NEURONS = DEF_NEURONS
) (
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [PATTERN_W-1:0] pattern_bits,
    input  wire logic [INDEX_W-1:0]   row_index,
    input  wire logic [INDEX_W-1:0]   col_index,
    input  wire logic                 init_done,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    localparam logic [INDEX_W:0] IDX_LIMIT = (INDEX_W + 1)'(NEURONS);

    logic row_ok;
    logic col_ok;

    assign in_ready = init_done && !q_full;
    assign q_push   = in_valid && in_ready;

    assign row_ok = {1'b0, row_index} < IDX_LIMIT;
    assign col_ok = {1'b0, col_index} < IDX_LIMIT;

    always_comb
    begin
        q_cmd.pattern = pattern_bits;
        q_cmd.row     = row_index;
        q_cmd.col     = col_index;
        q_cmd.rd_zero = !(row_ok && col_ok && (row_index != col_index));
        unique case (req_type)
            REQ_CLEAR: q_cmd.op = OP_CLEAR;
            REQ_TRAIN: q_cmd.op = OP_TRAIN;
            REQ_READ:  q_cmd.op = OP_READ;
            default:   q_cmd.op = OP_NOP;   // unused code: answered with a zero result
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/hwa_fifo.sv =====
// ---------------------------------------------------------------------------
// hwa_fifo - short command queue
// Decouples request intake from the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hwa_fifo
    import hwa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, clk, rst_n, push && full, "push into full queue")
    `ASSERT_NEVER(a_fifo_underflow, clk, rst_n, pop && empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== sv/hwa_back.sv =====
// ---------------------------------------------------------------------------
// hwa_back - sequencer over the pair-sum store
// Runs clear, train and read commands row by row and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hwa_back
    import hwa_pkg::*;
#(
    parameter int NEURONS      = DEF_NEURONS,
    parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_empty,
    input  wire cmd_t                       q_cmd,
    output logic                            q_pop,
    output logic                            init_done,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SUM_W-1:0]         raw_sum,
    output logic signed [WEIGHT_W-1:0]      weight_fixed,
    output logic        [COUNT_W-1:0]       pattern_count,
    output logic                            saturated
);

    localparam int ROW_W    = $clog2(NEURONS);
    localparam int CNT_W    = $clog2(NEURONS + 1);
    localparam int ROW_BITS = NEURONS * SUM_W;
    localparam int SHIFT    = FRAC_W - ROW_W;
    localparam int WIDE_W   = SUM_W + FRAC_W;
    localparam int CAP_INT  = (MAX_PATTERNS < COUNT_LIM) ? MAX_PATTERNS : COUNT_LIM;

    localparam logic [COUNT_W-1:0]       COUNT_CAP = COUNT_W'(CAP_INT);
    localparam logic [CNT_W-1:0]         ROW_END   = CNT_W'(NEURONS);
    localparam logic [CNT_W-1:0]         ROW_LAST  = CNT_W'(NEURONS - 1);
    localparam logic signed [SUM_W-1:0]  SUM_MAX   = SUM_W'(SUM_LIMIT);
    localparam logic signed [SUM_W-1:0]  SUM_MIN   = SUM_W'(-SUM_LIMIT);
    localparam logic signed [SUM_W-1:0]  SUM_ONE   = SUM_W'(1);
    localparam logic signed [WIDE_W-1:0] W_MAX     = WIDE_W'(WEIGHT_MAX);
    localparam logic signed [WIDE_W-1:0] W_MIN     = WIDE_W'(WEIGHT_MIN);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CLEAR = 5'b00100,
        ST_TRAIN = 5'b01000,
        ST_READ  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               flag_reg, flag_next;
    logic [NEURONS-1:0] pat_reg, pat_next;
    logic [ROW_W-1:0]   col_reg, col_next;
    logic               rdzero_reg, rdzero_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]    raw_reg, raw_next;
    logic signed [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [COUNT_W-1:0]         pcount_reg, pcount_next;
    logic                       sat_reg, sat_next;

    // store port
    logic                ram_wr_en;
    logic [ROW_W-1:0]    ram_wr_addr;
    logic [ROW_BITS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_addr;
    logic [ROW_BITS-1:0] ram_rd_data;

    // row update datapath
    logic [CNT_W-1:0]        row_dec;
    logic [ROW_W-1:0]        prev_row;
    logic                    bit_i;
    logic signed [SUM_W-1:0] lane_old [NEURONS];
    logic signed [SUM_W-1:0] lane_new [NEURONS];
    logic [NEURONS-1:0]      lane_sat;
    logic [ROW_BITS-1:0]     upd_row;
    logic                    upd_sat;

    // read datapath
    logic signed [SUM_W-1:0]    rd_raw;
    logic signed [WIDE_W-1:0]   rd_wide;
    logic signed [WIDE_W-1:0]   rd_clamp;
    logic signed [WEIGHT_W-1:0] rd_weight;

    logic slot_free;
    logic load;
    logic signed [SUM_W-1:0]    load_raw;
    logic signed [WEIGHT_W-1:0] load_weight;

    hwa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NEURONS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign init_done     = (state_reg != ST_INIT);
    assign out_valid     = out_valid_reg;
    assign raw_sum       = raw_reg;
    assign weight_fixed  = weight_reg;
    assign pattern_count = pcount_reg;
    assign saturated     = sat_reg;
    assign slot_free     = !out_valid_reg || out_ready;

    // row i update: lane j moves towards agreement, diagonal untouched
    assign row_dec  = CNT_W'(row_reg - 1'b1);
    assign prev_row = row_dec[ROW_W-1:0];
    assign bit_i    = pat_reg[prev_row];

    always_comb
    begin
        for (int j = 0; j < NEURONS; j++)
        begin
            lane_old[j] = $signed(ram_rd_data[j*SUM_W +: SUM_W]);
            lane_new[j] = lane_old[j];
            lane_sat[j] = 1'b0;
            if (ROW_W'(j) != prev_row)
            begin
                if (pat_reg[j] == bit_i)
                begin
                    if (lane_old[j] >= SUM_MAX)
                        lane_sat[j] = 1'b1;
                    else
                        lane_new[j] = lane_old[j] + SUM_ONE;
                end
                else
                begin
                    if (lane_old[j] <= SUM_MIN)
                        lane_sat[j] = 1'b1;
                    else
                        lane_new[j] = lane_old[j] - SUM_ONE;
                end
            end
            upd_row[j*SUM_W +: SUM_W] = lane_new[j];
        end
        upd_sat = |lane_sat;
    end

    // read: pick the column, scale by 2^16 / NEURONS, clamp
    always_comb
    begin
        rd_raw  = rdzero_reg ? '0 : lane_old[col_reg];
        rd_wide = WIDE_W'(rd_raw) <<< SHIFT;
        if (rd_wide > W_MAX)
            rd_clamp = W_MAX;
        else if (rd_wide < W_MIN)
            rd_clamp = W_MIN;
        else
            rd_clamp = rd_wide;
        rd_weight = rd_clamp[WEIGHT_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        count_next  = count_reg;
        flag_next   = flag_reg;
        pat_next    = pat_reg;
        col_next    = col_reg;
        rdzero_next = rdzero_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = row_reg[ROW_W-1:0];
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = q_cmd.row[ROW_W-1:0];

        q_pop       = 1'b0;
        load        = 1'b0;
        load_raw    = '0;
        load_weight = '0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                if (row_reg == ROW_LAST)
                begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                    load       = (state_reg == ST_CLEAR);
                end
                else
                begin
                    row_next = CNT_W'(row_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop    = 1'b1;
                    row_next = '0;
                    unique case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            flag_next  = 1'b0;
                            state_next = ST_CLEAR;
                        end
                        OP_TRAIN:
                        begin
                            pat_next = q_cmd.pattern[NEURONS-1:0];
                            if (count_reg >= COUNT_CAP)
                                flag_next = 1'b1;
                            else
                                count_next = COUNT_W'(count_reg + 1'b1);
                            state_next = ST_TRAIN;
                        end
                        OP_READ:
                        begin
                            ram_rd_en   = 1'b1;
                            col_next    = q_cmd.col[ROW_W-1:0];
                            rdzero_next = q_cmd.rd_zero;
                            state_next  = ST_READ;
                        end
                        OP_NOP:
                        begin
                            load = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_TRAIN:
            begin
                // read row k while row k-1 is written back
                ram_rd_en   = (row_reg != ROW_END);
                ram_rd_addr = row_reg[ROW_W-1:0];
                if (row_reg != '0)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = prev_row;
                    ram_wr_data = upd_row;
                    flag_next   = flag_reg | upd_sat;
                end
                if (row_reg == ROW_END)
                begin
                    row_next   = '0;
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = CNT_W'(row_reg + 1'b1);
                end
            end
            ST_READ:
            begin
                load        = 1'b1;
                load_raw    = rd_raw;
                load_weight = rd_weight;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // result register
        out_valid_next = out_valid_reg;
        raw_next       = raw_reg;
        weight_next    = weight_reg;
        pcount_next    = pcount_reg;
        sat_next       = sat_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            raw_next       = load_raw;
            weight_next    = load_weight;
            pcount_next    = count_next;
            sat_next       = flag_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg    <= pat_next;
        col_reg    <= col_next;
        rdzero_reg <= rdzero_next;
        raw_reg    <= raw_next;
        weight_reg <= weight_next;
        pcount_reg <= pcount_next;
        sat_reg    <= sat_next;
    end

    `ASSERT_IMPL(a_no_rw_clash, clk, rst_n, ram_wr_en && ram_rd_en,
                 ram_wr_addr != ram_rd_addr, "store read and write hit the same row")
    `ASSERT_IMPL(a_pop_when_idle, clk, rst_n, q_pop,
                 (state_reg == ST_IDLE) && slot_free, "command taken while busy")
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, load,
                 !out_valid_reg || out_ready, "result overwritten before taken")

endmodule

`default_nettype wire

// ===== sv/hebbian_weight_accumulator.sv =====
// ---------------------------------------------------------------------------
// hebbian_weight_accumulator - Hopfield weight matrix by Hebbian outer products
// Throughput set by the sequencer and the one-row-a-cycle store port: it takes commands
// only in idle, after the previous one is through; a train streams every row, a clear
// zeroes every row, a read fetches one row, an unused code answers from idle; a result
// left waiting on out_ready holds it in idle.
// Reset: asynchronous, active low; a clearing pass then zeroes the store row by row,
// with in_ready low until it ends.
// ---------------------------------------------------------------------------
`default_nettype none

module hebbian_weight_accumulator
    import hwa_pkg::*;
#(
    // number of neurons; a power of two from 2 to 64
    parameter int NEURONS      = DEF_NEURONS,
    // training count cap (further capped at 255)
    parameter int MAX_PATTERNS = DEF_MAX_PATTERNS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // request channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [REQ_W-1:0]       req_type,
    input  wire logic [PATTERN_W-1:0]   pattern_bits,
    input  wire logic [INDEX_W-1:0]     row_index,
    input  wire logic [INDEX_W-1:0]     col_index,

    // result channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [SUM_W-1:0]     raw_sum,
    output logic signed [WEIGHT_W-1:0]  weight_fixed,
    output logic        [COUNT_W-1:0]   pattern_count,
    output logic                        saturated
);

    // Structure:
    //   front  - decodes req_type, flags reads that answer zero (diagonal or an
    //            index beyond the network) and pushes a command word.
    //   queue  - a two-entry command queue, so requests keep flowing in while
    //            the sequencer is busy or a result is waiting to be taken.
    //   back   - sequencer over the pair-sum store. The store holds the full
    //            symmetric matrix, one row of NEURONS sums per RAM word. A train
    //            request streams the rows: read row k, write back updated row
    //            k-1 in the same cycle. Reads fetch one row and mux the column.
    //            The result lives in a single output register.

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic init_done;

    hwa_front #(
        .NEURONS (NEURONS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .pattern_bits (pattern_bits),
        .row_index    (row_index),
        .col_index    (col_index),
        .init_done    (init_done),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (front_cmd)
    );

    hwa_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    hwa_back #(
        .NEURONS      (NEURONS),
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (back_cmd),
        .q_pop         (q_pop),
        .init_done     (init_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_sum       (raw_sum),
        .weight_fixed  (weight_fixed),
        .pattern_count (pattern_count),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire
